// ----- rtl/core/rtpe_pkg.sv -----
// Shared types and constants for the rooted type profile edge count unit.
// No dependencies; every other file in rtl/core but rtpe_ram imports this package.
`timescale 1ns / 1ps

package rtpe_pkg;

  localparam int DEF_MAX_VERTICES = 32;
  localparam int DEF_MAX_ROOTS    = 8;
  localparam int DEF_MAX_CLASSES  = 8;
  localparam int DEF_COUNT_WIDTH  = 48;

  localparam int ROW_W      = 32;
  localparam int ROW_IDX_W  = 5;
  localparam int CLS_W      = 3;
  localparam int PAIR_DEPTH = 64;
  localparam int PAIR_AW    = 6;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TUPLE_SIZE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_ADJACENCY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_MASKS    = 3'd4;

  typedef struct packed {
    logic [5:0]  vertex_count;
    logic [3:0]  tuple_size;
    logic [3:0]  class_count;
    logic [63:0] type_adjacency;
    logic [63:0] class_masks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    vertex_count:   6'd32,
    tuple_size:     4'd1,
    class_count:    4'd1,
    type_adjacency: 64'd0,
    class_masks:    64'd0
  };

  // Class lookup result for one vertex.
  typedef struct packed {
    logic             valid;
    logic [CLS_W-1:0] idx;
  } cls_t;

endpackage

// ----- rtl/core/rooted_type_profile_edge_count_unit.sv -----
// Top level: configuration registers, stream packing and the sequencer.
// Depends on rtpe_pkg and rtpe_ctrl (which holds the memories).
//
//  channel | direction | fields
//  s_*     | in        | tdata: row_bits[31:0], row_index[36:32]; tlast: last_row
//  m_*     | out       | tdata: count_value, class_low, class_high; tuser: is_tuple_count,
//          |           | unmatched_profile; tlast: last_result
//  cfg_*   | in        | cfg_index: register number, cfg_data: value; always ready
//
// Rows are taken one per cycle while the sequencer is idle. The last row starts a
// depth-first search over the row memory and a tally for each complete tuple, all
// through the single row memory port. Results then follow one at a time; a stall
// holds the sequencer. After reset a pass clears all 64 pair counters before rows
// are taken.
`timescale 1ns / 1ps

module rooted_type_profile_edge_count_unit #(
  parameter int MAX_VERTICES = rtpe_pkg::DEF_MAX_VERTICES,
  parameter int MAX_ROOTS    = rtpe_pkg::DEF_MAX_ROOTS,
  parameter int MAX_CLASSES  = rtpe_pkg::DEF_MAX_CLASSES,
  parameter int COUNT_WIDTH  = rtpe_pkg::DEF_COUNT_WIDTH,
  parameter int ODW          = ((COUNT_WIDTH + 2 * rtpe_pkg::CLS_W + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [39:0]                    s_tdata,   // row_bits, row_index
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ODW-1:0]                 m_tdata,   // count_value, class_low, class_high
  output logic [1:0]                     m_tuser,   // is_tuple_count, unmatched_profile
  output logic                           m_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rtpe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data
);
  import rtpe_pkg::*;

  cfg_t                   cfg;
  logic [COUNT_WIDTH-1:0] count_value;
  logic [CLS_W-1:0]       class_low, class_high;
  logic                   is_tuple_count, unmatched_profile;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_VERTEX_COUNT:   cfg.vertex_count   <= cfg_data[5:0];
        REG_TUPLE_SIZE:     cfg.tuple_size     <= cfg_data[3:0];
        REG_CLASS_COUNT:    cfg.class_count    <= cfg_data[3:0];
        REG_TYPE_ADJACENCY: cfg.type_adjacency <= cfg_data;
        REG_CLASS_MASKS:    cfg.class_masks    <= cfg_data;
        default: ;
      endcase
    end
  end

  rtpe_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_ROOTS    (MAX_ROOTS),
    .MAX_CLASSES  (MAX_CLASSES),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .in_valid          (s_tvalid),
    .in_ready          (s_tready),
    .row_bits          (s_tdata[31:0]),
    .row_index         (s_tdata[36:32]),
    .last_row          (s_tlast),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .count_value       (count_value),
    .class_low         (class_low),
    .class_high        (class_high),
    .is_tuple_count    (is_tuple_count),
    .unmatched_profile (unmatched_profile),
    .last_result       (m_tlast)
  );

  assign m_tdata = ODW'({class_high, class_low, count_value});
  assign m_tuser = {unmatched_profile, is_tuple_count};

endmodule

// ----- rtl/core/rtpe_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// Uses no package items; read returns the old data on a same-address write.
`timescale 1ns / 1ps

module rtpe_ram #(
  parameter int W = 32,
  parameter int D = 32,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// ----- rtl/core/rtpe_classify.sv -----
// Root hit extraction and profile-to-class lookup for one adjacency row.
// Depends on rtpe_pkg for cls_t and CLS_W.
`timescale 1ns / 1ps

module rtpe_classify #(
  parameter int MAX_ROOTS   = rtpe_pkg::DEF_MAX_ROOTS,
  parameter int MAX_CLASSES = rtpe_pkg::DEF_MAX_CLASSES,
  parameter int VAW         = 5,
  parameter int RCW         = $clog2(MAX_ROOTS + 1)
) (
  input  logic [rtpe_pkg::ROW_W-1:0] row,
  input  logic [VAW-1:0]             roots [MAX_ROOTS],
  input  logic [RCW-1:0]             nk,
  input  logic [3:0]                 nc,
  input  logic [63:0]                class_masks,
  output logic [MAX_ROOTS-1:0]       hits,
  output rtpe_pkg::cls_t             cls
);
  import rtpe_pkg::*;

  logic [7:0] prof;

  always_comb begin
    prof = '0;
    cls  = '0;
    for (int r = 0; r < MAX_ROOTS; r++) begin
      hits[r] = row[roots[r]];
      if (r < nk) begin
        prof[r] = hits[r];
      end
    end
    // Later classes override earlier ones when masks repeat.
    for (int c = 0; c < MAX_CLASSES; c++) begin
      if (c < nc && class_masks[8*c +: 8] == prof) begin
        cls.valid = 1'b1;
        cls.idx   = CLS_W'(c);
      end
    end
  end

endmodule

// ----- rtl/core/rtpe_ctrl.sv -----
// Search, tally and emit sequencer around the row, class and pair memories.
// Depends on rtpe_pkg, rtpe_ram and rtpe_classify.
`timescale 1ns / 1ps

module rtpe_ctrl #(
  parameter int MAX_VERTICES = rtpe_pkg::DEF_MAX_VERTICES,
  parameter int MAX_ROOTS    = rtpe_pkg::DEF_MAX_ROOTS,
  parameter int MAX_CLASSES  = rtpe_pkg::DEF_MAX_CLASSES,
  parameter int COUNT_WIDTH  = rtpe_pkg::DEF_COUNT_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  rtpe_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rtpe_pkg::ROW_W-1:0]     row_bits,
  input  logic [rtpe_pkg::ROW_IDX_W-1:0] row_index,
  input  logic                           last_row,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [COUNT_WIDTH-1:0]         count_value,
  output logic [rtpe_pkg::CLS_W-1:0]     class_low,
  output logic [rtpe_pkg::CLS_W-1:0]     class_high,
  output logic                           is_tuple_count,
  output logic                           unmatched_profile,
  output logic                           last_result
);
  import rtpe_pkg::*;

  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int RAW = (MAX_ROOTS > 1) ? $clog2(MAX_ROOTS) : 1;
  localparam int RCW = $clog2(MAX_ROOTS + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_START, S_SRCH, S_SCHK, S_T1, S_T1C, S_T2, S_T2R,
    S_T2J, S_T2K, S_T2W, S_ETUP, S_EPRD, S_EPOUT, S_EWAIT
  } state_t;

  state_t state;

  logic [VCW-1:0]          nv, v, w, i, j;
  logic [RCW-1:0]          nk, d;
  logic [3:0]              nc, a, b;
  logic [VAW-1:0]          roots [MAX_ROOTS];
  logic [MAX_VERTICES-1:0] used;
  logic [COUNT_WIDTH-1:0]  tuple_total;
  logic                    unmatched_seen;
  logic [ROW_W-1:0]        row_i;
  cls_t                    ci;
  logic [PAIR_AW-1:0]      pa;
  logic [PAIR_AW-1:0]      clr;
  logic [RAW-1:0]          dm1;

  // Row memory
  logic             row_rd_en, row_wr_en;
  logic [VAW-1:0]   row_rd_addr;
  logic [ROW_W-1:0] row_q;

  // Class memory, one entry per vertex
  cls_t           cls_mem [MAX_VERTICES];
  cls_t           cls_q;
  logic           cls_rd_en;
  logic [VAW-1:0] cls_rd_addr;

  // Pair counter memory
  logic                   pr_en, pw_en;
  logic [PAIR_AW-1:0]     pr_addr, pw_addr;
  logic [COUNT_WIDTH-1:0] pr_data, pw_data;

  logic [MAX_ROOTS-1:0] hits;
  cls_t                 cls_now;
  logic [7:0]           want;
  logic                 ok;
  logic [CLS_W-1:0]     lo, hi;

  assign row_wr_en = in_valid && in_ready && (32'(row_index) < MAX_VERTICES);
  assign in_ready  = (state == S_IDLE);
  assign dm1       = RAW'(d - RCW'(1));

  rtpe_ram #(.W(ROW_W), .D(MAX_VERTICES)) u_rows (
    .clk     (clk),
    .rd_en   (row_rd_en),
    .rd_addr (row_rd_addr),
    .rd_data (row_q),
    .wr_en   (row_wr_en),
    .wr_addr (row_index[VAW-1:0]),
    .wr_data (row_bits)
  );

  rtpe_ram #(.W(COUNT_WIDTH), .D(PAIR_DEPTH)) u_pairs (
    .clk     (clk),
    .rd_en   (pr_en),
    .rd_addr (pr_addr),
    .rd_data (pr_data),
    .wr_en   (pw_en),
    .wr_addr (pw_addr),
    .wr_data (pw_data)
  );

  rtpe_classify #(
    .MAX_ROOTS   (MAX_ROOTS),
    .MAX_CLASSES (MAX_CLASSES),
    .VAW         (VAW)
  ) u_classify (
    .row         (row_q),
    .roots       (roots),
    .nk          (nk),
    .nc          (nc),
    .class_masks (cfg.class_masks),
    .hits        (hits),
    .cls         (cls_now)
  );

  always_ff @(posedge clk) begin
    if (cls_rd_en) begin
      cls_q <= cls_mem[cls_rd_addr];
    end
    if (state == S_T1C) begin
      cls_mem[w[VAW-1:0]] <= cls_now;
    end
  end

  // Candidate check: bit a of want must match the row's bit at root a.
  always_comb begin
    want = cfg.type_adjacency[8*d +: 8];
    ok   = 1'b1;
    for (int r = 0; r < MAX_ROOTS; r++) begin
      if (r < d && want[r] != hits[r]) begin
        ok = 1'b0;
      end
    end
    if (ci.idx < cls_q.idx) begin
      lo = ci.idx;
      hi = cls_q.idx;
    end else begin
      lo = cls_q.idx;
      hi = ci.idx;
    end
  end

  always_comb begin
    row_rd_en   = 1'b0;
    row_rd_addr = v[VAW-1:0];
    cls_rd_en   = 1'b0;
    cls_rd_addr = i[VAW-1:0];
    pr_en       = 1'b0;
    pr_addr     = {lo, hi};
    pw_en       = 1'b0;
    pw_addr     = pa;
    pw_data     = (pr_data == '1) ? pr_data : pr_data + COUNT_WIDTH'(1);
    unique case (state)
      S_CLEAR: begin
        pw_en   = 1'b1;
        pw_addr = clr;
        pw_data = '0;
      end
      S_SRCH: row_rd_en = (v < nv) && !used[v[VAW-1:0]];
      S_T1: begin
        row_rd_addr = w[VAW-1:0];
        row_rd_en   = (w < nv) && !used[w[VAW-1:0]];
      end
      S_T2: begin
        row_rd_addr = i[VAW-1:0];
        row_rd_en   = (i < nv) && !used[i[VAW-1:0]];
        cls_rd_en   = row_rd_en;
      end
      S_T2J: begin
        cls_rd_addr = j[VAW-1:0];
        cls_rd_en   = (j < nv);
      end
      S_T2K: pr_en = cls_q.valid && !used[j[VAW-1:0]] && row_i[j[VAW-1:0]];
      S_T2W: pw_en = 1'b1;
      S_EPRD: begin
        // Read out and clear the counter in the same cycle.
        pr_en   = 1'b1;
        pr_addr = {a[CLS_W-1:0], b[CLS_W-1:0]};
        pw_en   = 1'b1;
        pw_addr = {a[CLS_W-1:0], b[CLS_W-1:0]};
        pw_data = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr            <= '0;
      out_valid      <= 1'b0;
      tuple_total    <= '0;
      unmatched_seen <= 1'b0;
      d              <= '0;
      used           <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + PAIR_AW'(1);
          if (clr == PAIR_AW'(PAIR_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && last_row) begin
            state <= S_START;
          end
        end
        S_START: begin
          nv <= (cfg.vertex_count > 6'(MAX_VERTICES)) ? VCW'(MAX_VERTICES)
                                                     : VCW'(cfg.vertex_count);
          nk <= (cfg.tuple_size > 4'(MAX_ROOTS)) ? RCW'(MAX_ROOTS)
                                                : RCW'(cfg.tuple_size);
          nc <= (cfg.class_count > 4'(MAX_CLASSES)) ? 4'(MAX_CLASSES) : cfg.class_count;
          d    <= '0;
          v    <= '0;
          used <= '0;
          if (cfg.tuple_size == 4'd0) begin
            tuple_total <= (tuple_total == '1) ? tuple_total
                                               : tuple_total + COUNT_WIDTH'(1);
            w     <= '0;
            state <= S_T1;
          end else begin
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (v >= nv) begin
            if (d == '0) begin
              state <= S_ETUP;
            end else begin
              d              <= d - RCW'(1);
              used[roots[dm1]] <= 1'b0;
              v              <= VCW'(roots[dm1]) + VCW'(1);
            end
          end else if (used[v[VAW-1:0]]) begin
            v <= v + VCW'(1);
          end else begin
            state <= S_SCHK;
          end
        end
        S_SCHK: begin
          if (ok) begin
            roots[d[RAW-1:0]] <= v[VAW-1:0];
            used[v[VAW-1:0]]  <= 1'b1;
            d                 <= d + RCW'(1);
            if (d + RCW'(1) == nk) begin
              tuple_total <= (tuple_total == '1) ? tuple_total
                                                 : tuple_total + COUNT_WIDTH'(1);
              w     <= '0;
              state <= S_T1;
            end else begin
              v     <= '0;
              state <= S_SRCH;
            end
          end else begin
            v     <= v + VCW'(1);
            state <= S_SRCH;
          end
        end
        S_T1: begin
          if (w >= nv) begin
            i     <= '0;
            state <= S_T2;
          end else if (used[w[VAW-1:0]]) begin
            w <= w + VCW'(1);
          end else begin
            state <= S_T1C;
          end
        end
        S_T1C: begin
          if (!cls_now.valid) begin
            unmatched_seen <= 1'b1;
          end
          w     <= w + VCW'(1);
          state <= S_T1;
        end
        S_T2: begin
          if (i >= nv) begin
            // Tally done: return to the search one level up.
            if (d == '0) begin
              state <= S_ETUP;
            end else begin
              d                <= d - RCW'(1);
              used[roots[dm1]] <= 1'b0;
              v                <= VCW'(roots[dm1]) + VCW'(1);
              state            <= S_SRCH;
            end
          end else if (used[i[VAW-1:0]]) begin
            i <= i + VCW'(1);
          end else begin
            state <= S_T2R;
          end
        end
        S_T2R: begin
          row_i <= row_q;
          ci    <= cls_q;
          if (cls_q.valid) begin
            j     <= i + VCW'(1);
            state <= S_T2J;
          end else begin
            i     <= i + VCW'(1);
            state <= S_T2;
          end
        end
        S_T2J: begin
          if (j >= nv) begin
            i     <= i + VCW'(1);
            state <= S_T2;
          end else begin
            state <= S_T2K;
          end
        end
        S_T2K: begin
          if (pr_en) begin
            pa    <= pr_addr;
            state <= S_T2W;
          end else begin
            j     <= j + VCW'(1);
            state <= S_T2J;
          end
        end
        S_T2W: begin
          j     <= j + VCW'(1);
          state <= S_T2J;
        end
        S_ETUP: begin
          count_value       <= tuple_total;
          class_low         <= '0;
          class_high        <= '0;
          is_tuple_count    <= 1'b1;
          unmatched_profile <= unmatched_seen;
          last_result       <= (nc == 4'd0);
          out_valid         <= 1'b1;
          a                 <= '0;
          b                 <= '0;
          state             <= S_EWAIT;
        end
        S_EPRD: state <= S_EPOUT;
        S_EPOUT: begin
          count_value    <= pr_data;
          class_low      <= a[CLS_W-1:0];
          class_high     <= b[CLS_W-1:0];
          is_tuple_count <= 1'b0;
          last_result    <= (a == nc - 4'd1) && (b == nc - 4'd1);
          out_valid      <= 1'b1;
          state          <= S_EWAIT;
        end
        S_EWAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_result) begin
              tuple_total    <= '0;
              unmatched_seen <= 1'b0;
              state          <= S_IDLE;
            end else begin
              if (!is_tuple_count) begin
                if (b == nc - 4'd1) begin
                  a <= a + 4'd1;
                  b <= a + 4'd1;
                end else begin
                  b <= b + 4'd1;
                end
              end
              state <= S_EPRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input accepted while a result is pending");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCHK) |-> (d < nk))
    else $error("search depth reached tuple size while checking a candidate");

  a_pair_port_same: assert property (@(posedge clk) disable iff (rst)
    (pr_en && pw_en) |-> (pr_addr == pw_addr))
    else $error("pair memory read and write collide at different entries");

  a_tally_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_T1 && $past(state) == S_SCHK) |-> (d == nk))
    else $error("tally started before the tuple was complete");

endmodule

// ----- tb/rooted_type_profile_edge_count_unit_test.sv -----
// Self-checking testbench for rooted_type_profile_edge_count_unit: loads random graphs
// row by row, predicts the tuple and class pair counts, and checks every result word.
// Depends on rtpe_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module rooted_type_profile_edge_count_unit_test;
  import rtpe_pkg::*;

  localparam logic [47:0] COUNT_SAT   = 48'hFFFF_FFFF_FFFF;
  localparam int          QUIET_LIMIT = 600000;

  typedef struct packed {
    logic [47:0] count;
    logic [2:0]  cls_lo;
    logic [2:0]  cls_hi;
    logic        is_tuple;
    logic        unmatched;
    logic        last;
  } count_word_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  rooted_type_profile_edge_count_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Register mirror.
  logic [5:0]  vc_reg = 6'd32;
  logic [3:0]  ts_reg = 4'd1;
  logic [3:0]  cc_reg = 4'd1;
  logic [63:0] adj_reg = '0;
  logic [63:0] mask_reg = '0;

  // Predictor state.
  logic [31:0] row_mem [32];
  int          root_at [8];
  logic [31:0] taken;
  logic [47:0] tuple_cnt;
  logic [47:0] pair_cnt [64];
  bit          unmatched;
  int          n_vert, n_root, n_cls;

  count_word_t pending_counts[$];
  int          error_count = 0;
  int          rows_sent = 0;
  bit          burst = 0;
  int          stall_left = 0;
  int          quiet = 0;

  function automatic logic [47:0] sat_inc(logic [47:0] x);
    return (x >= COUNT_SAT) ? COUNT_SAT : x + 48'd1;
  endfunction

  function automatic int class_of(int prof);
    int found;
    found = -1;
    for (int c = 0; c < n_cls; c++)
      if (int'(mask_reg[8*c +: 8]) == prof) found = c;
    return found;
  endfunction

  function automatic void tally_tuple();
    int vid [32];
    int cls [32];
    int m, prof, lo, hi;
    m = 0;
    for (int w = 0; w < n_vert; w++) begin
      if (taken[w]) continue;
      prof = 0;
      for (int i = 0; i < n_root; i++)
        if (row_mem[w][root_at[i]]) prof |= 1 << i;
      vid[m] = w;
      cls[m] = class_of(prof);
      if (cls[m] < 0) unmatched = 1;
      m++;
    end
    tuple_cnt = sat_inc(tuple_cnt);
    for (int i = 0; i < m; i++) begin
      if (cls[i] < 0) continue;
      for (int j = i + 1; j < m; j++) begin
        if (cls[j] < 0 || !row_mem[vid[i]][vid[j]]) continue;
        lo = (cls[i] < cls[j]) ? cls[i] : cls[j];
        hi = (cls[i] < cls[j]) ? cls[j] : cls[i];
        pair_cnt[lo*8 + hi] = sat_inc(pair_cnt[lo*8 + hi]);
      end
    end
  endfunction

  function automatic void walk_roots(int depth);
    logic [7:0] want;
    bit ok;
    if (depth >= n_root) begin
      tally_tuple();
      return;
    end
    want = adj_reg[8*depth +: 8];
    for (int v = 0; v < n_vert; v++) begin
      if (taken[v]) continue;
      ok = 1;
      for (int a = 0; a < depth; a++)
        if (want[a] != row_mem[v][root_at[a]]) ok = 0;
      if (!ok) continue;
      root_at[depth] = v;
      taken[v] = 1;
      walk_roots(depth + 1);
      taken[v] = 0;
    end
  endfunction

  function automatic void clear_graph();
    for (int i = 0; i < 32; i++) row_mem[i] = '0;
    for (int i = 0; i < 64; i++) pair_cnt[i] = '0;
    for (int i = 0; i < 8; i++) root_at[i] = 0;
    taken = '0;
    tuple_cnt = '0;
    unmatched = 0;
  endfunction

  function automatic void predict_counts();
    count_word_t w;
    n_vert = (vc_reg > 32) ? 32 : int'(vc_reg);
    n_root = (ts_reg > 8) ? 8 : int'(ts_reg);
    n_cls  = (cc_reg > 8) ? 8 : int'(cc_reg);
    taken = '0;
    walk_roots(0);
    w = '{count: tuple_cnt, cls_lo: 3'd0, cls_hi: 3'd0, is_tuple: 1'b1,
          unmatched: unmatched, last: 1'b0};
    pending_counts.push_back(w);
    for (int a = 0; a < n_cls; a++)
      for (int b = a; b < n_cls; b++) begin
        w = '{count: pair_cnt[a*8 + b], cls_lo: a[2:0], cls_hi: b[2:0], is_tuple: 1'b0,
              unmatched: unmatched, last: 1'b0};
        pending_counts.push_back(w);
      end
    pending_counts[$].last = 1'b1;
    clear_graph();
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    count_word_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_counts.size() == 0) begin
        report("unexpected word", m_tdata, 0);
      end else begin
        w = pending_counts.pop_front();
        if (m_tdata[47:0] !== w.count) report("count_value", m_tdata[47:0], w.count);
        if (m_tdata[50:48] !== w.cls_lo) report("class_low", m_tdata[50:48], w.cls_lo);
        if (m_tdata[53:51] !== w.cls_hi) report("class_high", m_tdata[53:51], w.cls_hi);
        if (m_tuser[0] !== w.is_tuple) report("is_tuple_count", m_tuser[0], w.is_tuple);
        if (m_tuser[1] !== w.unmatched) report("unmatched_profile", m_tuser[1], w.unmatched);
        if (m_tlast !== w.last) report("last_result", m_tlast, w.last);
      end
    end
  end

  // Output back-pressure: a random stall after each accepted word.
  always @(posedge clk) begin
    int n;
    if (rst) begin
      m_tready <= 0;
      stall_left <= 0;
    end else if (m_tvalid && m_tready) begin
      n = burst ? 0 : $urandom_range(0, 5);
      stall_left <= n;
      m_tready <= (n == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= (stall_left == 1);
    end else begin
      m_tready <= 1;
    end
  end

  // Watchdog on cycles with no handshake anywhere.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else if (quiet + 1 >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else
      quiet <= quiet + 1;
  end

  task automatic send_row(logic [31:0] bits, logic [4:0] idx, logic last);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {3'b000, idx, bits};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    rows_sent++;
    row_mem[idx] = bits;
    if (last) predict_counts();
  endtask

  task automatic wait_idle();
    s_tvalid <= 0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_VERTEX_COUNT:   vc_reg = value[5:0];
      REG_TUPLE_SIZE:     ts_reg = value[3:0];
      REG_CLASS_COUNT:    cc_reg = value[3:0];
      REG_TYPE_ADJACENCY: adj_reg = value;
      REG_CLASS_MASKS:    mask_reg = value;
      default: ;
    endcase
  endtask

  task automatic configure(int vc, int ts, int cc, logic [63:0] adj, logic [63:0] masks);
    wait_idle();
    write_reg(REG_VERTEX_COUNT, 64'(vc));
    write_reg(REG_TUPLE_SIZE, 64'(ts));
    write_reg(REG_CLASS_COUNT, 64'(cc));
    write_reg(REG_TYPE_ADJACENCY, adj);
    write_reg(REG_CLASS_MASKS, masks);
    cfg_valid <= 0;
  endtask

  // Sends every row the search reads, in shuffled order, plus some stray rows first.
  task automatic send_graph(int extra, int sparsity);
    int order[$];
    int n, j, t;
    logic [31:0] bits;
    n = (vc_reg > 32) ? 32 : int'(vc_reg);
    for (int i = 0; i < n; i++) order.push_back(i);
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    repeat (extra) send_row($urandom, $urandom_range(0, 31), 0);
    if (n == 0) order.push_back($urandom_range(0, 31));
    foreach (order[i]) begin
      bits = $urandom;
      repeat (sparsity) bits &= $urandom;
      send_row(bits, order[i], i == order.size() - 1);
    end
  endtask

  task automatic test_zero_sizes();
    configure(0, 0, 0, '1, '1);
    send_graph(0, 0);
    configure(3, 15, 15, 64'h0000_0000_0000_0100, 64'h0706_0504_0302_0100);
    send_graph(0, 0);
  endtask

  // Ordered induced 8-paths in a 9-vertex path graph.
  task automatic test_induced_path();
    logic [31:0] bits;
    configure(9, 8, 8, 64'h4020_1008_0402_0100, $urandom);
    for (int v = 8; v >= 0; v--) begin
      bits = '0;
      if (v > 0) bits[v-1] = 1;
      if (v < 8) bits[v+1] = 1;
      send_row(bits, v, v == 0);
    end
  endtask

  // Duplicate masks (higher class wins), a mask wider than K, unmatched profiles.
  task automatic test_duplicate_masks();
    configure(4, 2, 4, 64'h0000_0000_0000_0100, 64'h0000_0000_0004_0101);
    send_graph(1, 0);
    send_graph(0, 1);
  endtask

  task automatic test_random_graphs();
    int ts;
    logic [63:0] masks;
    while (rows_sent < 460) begin
      burst = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 24) == 0) begin
        configure($urandom_range(32, 63), $urandom_range(0, 1), $urandom_range(1, 15),
                  {$urandom, $urandom}, {$urandom, $urandom});
        send_graph(0, $urandom_range(0, 2));
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          ts = $urandom_range(0, 3);
          masks = {$urandom, $urandom};
          if ($urandom_range(0, 3) != 0)
            for (int c = 0; c < 8; c++) masks[8*c +: 8] = $urandom_range(0, (1 << ts) - 1);
          configure($urandom_range(1, 8), ts, $urandom_range(0, 9),
                    {$urandom, $urandom}, masks);
        end
        send_graph($urandom_range(0, 2), $urandom_range(0, 2));
      end
    end
    burst = 0;
  endtask

  initial begin
    clear_graph();
    rst <= 1;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Reset values of the registers first.
    send_graph(0, 3);
    test_zero_sizes();
    test_induced_path();
    test_duplicate_masks();
    test_random_graphs();
    wait_idle();
    repeat (200) @(posedge clk);
    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
